FILE: rtl/core/adet_pkg.sv
// Shared types and constants for the attach/detach event tracker.
// Used by adet_front, adet_cmd_fifo, adet_back and the top level.
// No dependencies.
package adet_pkg;

    // Widths of the item fields
    localparam int unsigned FUNC_W  = 3;
    localparam int unsigned COUNT_W = 31;
    localparam int unsigned DEVID_W = 7;
    localparam int unsigned MODE_W  = 2;

    // Stream packing: input tdata is present, change_count, sink_ready
    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned M_TDATA_W = 16;
    localparam int unsigned M_TUSER_W = 2;

    // Depth of the command queue between front and back
    localparam int unsigned CMD_DEPTH = 2;
    localparam int unsigned CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int unsigned CMD_CNT_W = $clog2(CMD_DEPTH + 1);

    // Depth of the pending event queue
    localparam int unsigned EVQ_DEPTH = 2;
    localparam int unsigned EVQ_CNT_W = $clog2(EVQ_DEPTH + 1);

    // Event kinds
    localparam logic EV_ATTACH = 1'b0;
    localparam logic EV_DETACH = 1'b1;

    // Item operation codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_START = 3'd0,
        FUNC_POLL  = 3'd1,
        FUNC_OPEN  = 3'd2,
        FUNC_CLOSE = 3'd3,
        FUNC_FAIL  = 3'd4,
        FUNC_NOP   = 3'd5
    } t_func;

    // Port state
    typedef enum logic [MODE_W-1:0] {
        PORT_CLOSED = 2'd0,
        PORT_OPEN   = 2'd1,
        PORT_FAULT  = 2'd2
    } t_port;

    // Classified request handed from front to back
    typedef struct packed {
        t_func       op;
        logic [1:0]  push_n;      // events to queue: 0, 1 or 2
        logic        ev_first;    // kind of the flip away from the old level
        logic        ev_second;   // kind of the return to the old level
        logic        sink_ready;
    } t_cmd;

endpackage

FILE: rtl/core/attach_detach_event_tracker.sv
// Attach/detach event tracker, top level: front end, command queue, back end.
// Depends on adet_pkg, adet_front, adet_cmd_fifo, adet_back.
//
//  channel | dir | handshake                  | payload
//  --------+-----+----------------------------+---------------------------------
//  s       | in  | i_s_tvalid / o_s_tready    | tuser func, tdata presence sample
//  m       | out | o_m_tvalid / i_m_tready    | tuser event flags, tdata arg/mode
//  cfg     | in  | i_cfg_valid / o_cfg_ready  | device_id
//
// A request is classified by the front, written into the command queue and
// then loaded into the back-end output register, from which its first result
// appears. The back end delivers one result per cycle while the sink is ready,
// one per request, or two when it releases two events. The two-entry command
// queue lets the front keep accepting while the sink stalls. Reset is
// synchronous, active low; it clears baseline, queues, port state and device_id.
module attach_detach_event_tracker import adet_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request stream
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,  // present, change_count[30:0], sink_ready, zeros
    input  logic [FUNC_W-1:0]    i_s_tuser,  // func
    // result stream
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,  // event_arg[6:0], port_mode[1:0], zeros
    output logic [M_TUSER_W-1:0] o_m_tuser,  // event_valid, event_kind
    output logic                 o_m_tlast,
    // configuration
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [DEVID_W-1:0]   i_cfg_data
);

    t_cmd               front_cmd;
    t_cmd               fifo_cmd;
    logic               fifo_full;
    logic               fifo_valid;
    logic               fifo_pop;
    logic               s_accept;
    logic               ev_valid;
    logic               ev_kind;
    logic [DEVID_W-1:0] ev_arg;
    logic [MODE_W-1:0]  mode;

    assign o_s_tready  = ~fifo_full;
    assign s_accept    = i_s_tvalid & o_s_tready;
    assign o_cfg_ready = 1'b1;

    adet_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (s_accept),
        .i_func         (i_s_tuser),
        .i_present      (i_s_tdata[0]),
        .i_change_count (i_s_tdata[COUNT_W:1]),
        .i_sink_ready   (i_s_tdata[COUNT_W+1]),
        .o_cmd          (front_cmd)
    );

    adet_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_accept),
        .i_cmd   (front_cmd),
        .o_full  (fifo_full),
        .i_pop   (fifo_pop),
        .o_valid (fifo_valid),
        .o_cmd   (fifo_cmd)
    );

    adet_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_valid & o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_cmd_valid   (fifo_valid),
        .i_cmd         (fifo_cmd),
        .o_cmd_pop     (fifo_pop),
        .o_valid       (o_m_tvalid),
        .i_ready       (i_m_tready),
        .o_event_valid (ev_valid),
        .o_event_kind  (ev_kind),
        .o_event_arg   (ev_arg),
        .o_port_mode   (mode),
        .o_last        (o_m_tlast)
    );

    // Pack the result fields
    assign o_m_tdata = {{(M_TDATA_W - DEVID_W - MODE_W){1'b0}}, mode, ev_arg};
    assign o_m_tuser = {ev_kind, ev_valid};

endmodule

FILE: rtl/core/adet_front.sv
// Front end: accepts requests, tracks the presence baseline, classifies
// each request into a command for the back end. Depends on adet_pkg.
module adet_front import adet_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [FUNC_W-1:0]  i_func,
    input  logic               i_present,
    input  logic [COUNT_W-1:0] i_change_count,
    input  logic               i_sink_ready,
    output t_cmd               o_cmd
);

    logic               r_seen_level;
    logic [COUNT_W-1:0] r_seen_count;
    logic               n_seen_level;
    logic [COUNT_W-1:0] n_seen_count;
    logic [COUNT_W-1:0] diff;
    logic               edge_seen;
    logic               two_edges;

    // Edge detection against the baseline, count difference wraps
    assign diff      = i_change_count - r_seen_count;
    assign edge_seen = (diff != '0) || (i_present != r_seen_level);
    assign two_edges = (diff[COUNT_W-1:1] != '0) && (i_present == r_seen_level);

    // Classify the request
    // a move to level 1 is an attach (kind 0), to level 0 a detach (kind 1)
    always_comb begin
        o_cmd            = '0;
        o_cmd.op         = FUNC_NOP;
        o_cmd.ev_first   = r_seen_level;
        o_cmd.ev_second  = ~r_seen_level;
        o_cmd.sink_ready = i_sink_ready;
        n_seen_level     = r_seen_level;
        n_seen_count     = r_seen_count;
        case (i_func)
            FUNC_START: begin
                o_cmd.op     = FUNC_START;
                n_seen_level = i_present;
                n_seen_count = i_change_count;
            end
            FUNC_POLL: begin
                o_cmd.op = FUNC_POLL;
                if (edge_seen) begin
                    o_cmd.push_n = two_edges ? 2'd2 : 2'd1;
                    n_seen_level = i_present;
                    n_seen_count = i_change_count;
                end
            end
            FUNC_OPEN:  o_cmd.op = FUNC_OPEN;
            FUNC_CLOSE: o_cmd.op = FUNC_CLOSE;
            FUNC_FAIL:  o_cmd.op = FUNC_FAIL;
            default:    o_cmd.op = FUNC_NOP;
        endcase
    end

    // Baseline registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_level <= 1'b0;
            r_seen_count <= '0;
        end else if (i_accept) begin
            r_seen_level <= n_seen_level;
            r_seen_count <= n_seen_count;
        end
    end

endmodule

FILE: rtl/core/adet_cmd_fifo.sv
// Short command queue between front and back end.
// Depends on adet_pkg for t_cmd and the queue depth.
module adet_cmd_fifo import adet_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd                 r_mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] r_wr_ptr;
    logic [CMD_PTR_W-1:0] r_rd_ptr;
    logic [CMD_CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CMD_CNT_W'(CMD_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: rtl/core/adet_back.sv
// Back end: pending event queue, port state, device id and the result
// output register. Depends on adet_pkg.
module adet_back import adet_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic [DEVID_W-1:0] i_cfg_data,
    // commands from the queue
    input  logic               i_cmd_valid,
    input  t_cmd               i_cmd,
    output logic               o_cmd_pop,
    // results
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_event_valid,
    output logic               o_event_kind,
    output logic [DEVID_W-1:0] o_event_arg,
    output logic [MODE_W-1:0]  o_port_mode,
    output logic               o_last
);

    logic [DEVID_W-1:0]   r_device_id;
    logic [EVQ_CNT_W-1:0] r_pend_cnt;
    logic                 r_pend [EVQ_DEPTH];
    t_port                r_port;
    // output register: results still to deliver for the current request
    logic [1:0]           r_rem;
    logic                 r_kind [2];
    logic                 r_evt;
    t_port                r_mode;

    logic [EVQ_CNT_W-1:0] n_pend_cnt;
    logic                 n_pend [EVQ_DEPTH];
    t_port                n_port;
    logic [1:0]           n_rem;
    logic                 n_evt;
    logic                 rel_kind [2];
    logic                 load;
    logic                 ev;

    assign load      = i_cmd_valid && ((r_rem == 2'd0) || ((r_rem == 2'd1) && i_ready));
    assign o_cmd_pop = load;

    // Apply one request to queue and port state
    always_comb begin
        n_pend_cnt  = r_pend_cnt;
        n_pend[0]   = r_pend[0];
        n_pend[1]   = r_pend[1];
        n_port      = r_port;
        n_rem       = 2'd1;
        n_evt       = 1'b0;
        rel_kind[0] = 1'b0;
        rel_kind[1] = 1'b0;
        ev          = 1'b0;
        case (i_cmd.op)
            FUNC_START: begin
                n_pend_cnt = '0;
                n_port     = PORT_CLOSED;
            end
            FUNC_POLL: begin
                // up to two events, each may move the port and drops the oldest when full
                for (int i = 0; i < 2; i++) begin
                    if (i_cmd.push_n > 2'(i)) begin
                        ev = (i == 0) ? i_cmd.ev_first : i_cmd.ev_second;
                        if (ev == EV_ATTACH) begin
                            if (n_port == PORT_FAULT) n_port = PORT_CLOSED;
                        end else begin
                            if (n_port == PORT_OPEN) n_port = PORT_FAULT;
                        end
                        if (n_pend_cnt < EVQ_CNT_W'(EVQ_DEPTH)) begin
                            n_pend[n_pend_cnt[0]] = ev;
                            n_pend_cnt            = n_pend_cnt + 1'b1;
                        end else begin
                            n_pend[0] = n_pend[1];
                            n_pend[1] = ev;
                        end
                    end
                end
                // release everything queued while the sink is ready
                if (i_cmd.sink_ready && (n_pend_cnt != '0)) begin
                    n_evt       = 1'b1;
                    n_rem       = 2'(n_pend_cnt);
                    rel_kind[0] = n_pend[0];
                    rel_kind[1] = n_pend[1];
                    n_pend_cnt  = '0;
                end
            end
            FUNC_OPEN:  n_port = PORT_OPEN;
            FUNC_CLOSE: n_port = PORT_CLOSED;
            FUNC_FAIL:  n_port = PORT_FAULT;
            default:    n_port = r_port;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_id <= '0;
            r_pend_cnt  <= '0;
            r_port      <= PORT_CLOSED;
            r_rem       <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                r_device_id <= i_cfg_data;
            end
            if (load) begin
                r_pend_cnt <= n_pend_cnt;
                r_port     <= n_port;
                r_rem      <= n_rem;
            end else if (o_valid && i_ready) begin
                r_rem <= r_rem - 1'b1;
            end
        end
    end

    // Payload: queued kinds and the result register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_pend[0] <= n_pend[0];
            r_pend[1] <= n_pend[1];
            r_kind[0] <= rel_kind[0];
            r_kind[1] <= rel_kind[1];
            r_evt     <= n_evt;
            r_mode    <= n_port;
        end else if (o_valid && i_ready) begin
            r_kind[0] <= r_kind[1];
        end
    end

    assign o_valid       = (r_rem != 2'd0);
    assign o_event_valid = r_evt;
    assign o_event_kind  = r_evt & r_kind[0];
    assign o_event_arg   = r_evt ? r_device_id : '0;
    assign o_port_mode   = r_mode;
    assign o_last        = (r_rem == 2'd1);

endmodule

FILE: dv/attach_detach_event_tracker_tb.sv
// Self-checking testbench for attach_detach_event_tracker: drives presence requests and
// commands on the stream input and compares every result with a built-in predictor.
// Depends on adet_pkg and the attach_detach_event_tracker RTL.
module attach_detach_event_tracker_tb;
    import adet_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          LIMIT_CYCLES = 200000;
    localparam int          REPORT_MAX   = 10;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          FUNC_MAX     = (1 << FUNC_W) - 1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // One result as seen on the output stream
    typedef struct {
        logic               ev_valid;
        logic               ev_kind;
        logic [DEVID_W-1:0] arg;
        logic [MODE_W-1:0]  mode;
        logic               last;
    } t_presence_result;

    // Predicts tracker results and checks them in order
    class presence_scoreboard;
        logic               last_level;
        logic [COUNT_W-1:0] last_count;
        logic               evq[EVQ_DEPTH];
        int unsigned        evq_fill;
        t_port              port_now;
        logic [DEVID_W-1:0] dev_id;
        t_presence_result   expected_q[$];
        int                 fail_count;

        function new();
            last_level = 1'b0;
            last_count = '0;
            evq_fill   = 0;
            port_now   = PORT_CLOSED;
            dev_id     = '0;
            fail_count = 0;
        endfunction

        function void set_device(logic [DEVID_W-1:0] value);
            dev_id = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Full queue drops its oldest event
        function void queue_event(logic kind);
            if (evq_fill < EVQ_DEPTH) begin
                evq[evq_fill] = kind;
                evq_fill++;
                return;
            end
            for (int i = 0; i + 1 < EVQ_DEPTH; i++) evq[i] = evq[i + 1];
            evq[EVQ_DEPTH - 1] = kind;
        endfunction

        function logic take_event();
            logic kind;
            kind = evq[0];
            for (int i = 0; i + 1 < EVQ_DEPTH; i++) evq[i] = evq[i + 1];
            evq_fill--;
            return kind;
        endfunction

        // Announce a move to the given level and update the port
        function void announce(logic level);
            if (level) begin
                if (port_now == PORT_FAULT) port_now = PORT_CLOSED;
                queue_event(EV_ATTACH);
            end else begin
                if (port_now == PORT_OPEN) port_now = PORT_FAULT;
                queue_event(EV_DETACH);
            end
        endfunction

        function void note_request(logic [FUNC_W-1:0] func, logic present,
                                   logic [COUNT_W-1:0] count, logic sink_ready);
            logic [COUNT_W-1:0] edges;
            logic               kinds[EVQ_DEPTH];
            int                 n;
            t_presence_result   res;
            n = 0;
            case (func)
                FUNC_START: begin
                    last_level = present;
                    last_count = count;
                    evq_fill   = 0;
                    port_now   = PORT_CLOSED;
                end
                FUNC_POLL: begin
                    // count difference wraps at 2^31
                    edges = count - last_count;
                    if (edges == 0 && present != last_level) edges = 1;
                    if (edges != 0) begin
                        last_count = count;
                        announce(!last_level);
                        if (edges >= 2 && present == last_level) announce(present);
                        last_level = present;
                    end
                    while (evq_fill > 0 && sink_ready && n < EVQ_DEPTH) begin
                        kinds[n] = take_event();
                        n++;
                    end
                end
                FUNC_OPEN:  port_now = PORT_OPEN;
                FUNC_CLOSE: port_now = PORT_CLOSED;
                FUNC_FAIL:  port_now = PORT_FAULT;
                default: ;
            endcase
            if (n == 0) begin
                res = '{1'b0, 1'b0, '0, port_now, 1'b1};
                expected_q.push_back(res);
            end
            for (int k = 0; k < n; k++) begin
                res = '{1'b1, kinds[k], dev_id, port_now, k == n - 1};
                expected_q.push_back(res);
            end
        endfunction

        function void check_result(logic [M_TUSER_W-1:0] tuser, logic [M_TDATA_W-1:0] tdata,
                                   logic tlast);
            t_presence_result got;
            t_presence_result want;
            got = '{tuser[0], tuser[1], tdata[DEVID_W-1:0],
                    tdata[DEVID_W +: MODE_W], tlast};
            if (expected_q.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("%0t: unexpected result valid=%0b kind=%0b arg=%0d mode=%0d last=%0b",
                             $realtime, got.ev_valid, got.ev_kind, got.arg, got.mode, got.last);
                return;
            end
            want = expected_q.pop_front();
            if (got.ev_valid !== want.ev_valid || got.ev_kind !== want.ev_kind ||
                got.arg !== want.arg || got.mode !== want.mode || got.last !== want.last) begin
                fail_count++;
                if (fail_count <= REPORT_MAX) begin
                    $write("%0t: mismatch exp valid=%0b kind=%0b arg=%0d mode=%0d last=%0b",
                           $realtime, want.ev_valid, want.ev_kind, want.arg, want.mode,
                           want.last);
                    $display(" / got valid=%0b kind=%0b arg=%0d mode=%0d last=%0b",
                             got.ev_valid, got.ev_kind, got.arg, got.mode, got.last);
                end
            end
        endfunction
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata   = '0;
    logic [FUNC_W-1:0]    i_s_tuser   = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic [M_TUSER_W-1:0] o_m_tuser;
    logic                 o_m_tlast;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [DEVID_W-1:0]   i_cfg_data  = '0;

    int                   tx_idle_pct = 0;
    int                   rx_idle_pct = 0;
    logic                 rx_hold     = 1'b0;
    int                   cycle_count = 0;
    logic                 bk_level;
    logic [COUNT_W-1:0]   bk_count;
    presence_scoreboard   tracker_sb;

    attach_detach_event_tracker i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result sink: check accepted results, then pick next ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            tracker_sb.check_result(o_m_tuser, o_m_tdata, o_m_tlast);
        i_m_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    // Offer one request and wait until it is taken
    task automatic send_req(logic [FUNC_W-1:0] func, logic present,
                            logic [COUNT_W-1:0] count, logic sink_ready);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= func;
        i_s_tdata  <= S_TDATA_W'({sink_ready, count, present});
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        tracker_sb.note_request(func, present, count, sink_ready);
    endtask

    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (tracker_sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_device(logic [DEVID_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        tracker_sb.set_device(value);
    endtask

    // Long sink stall so the block fills up and back-pressures requests
    task automatic hold_sink(int cycles);
        rx_hold <= 1'b1;
        repeat (cycles) @(posedge i_clk);
        rx_hold <= 1'b0;
    endtask

    // Edge cases: level-only flips, return runs, queue overflow, wrap, commands
    task automatic run_directed();
        send_req(FUNC_START, 1'b0, '0, 1'b1);
        send_req(FUNC_FAIL, 1'b0, '0, 1'b0);
        send_req(FUNC_POLL, 1'b1, '0, 1'b1);
        send_req(FUNC_OPEN, 1'b1, '0, 1'b1);
        send_req(FUNC_POLL, 1'b1, 31'd2, 1'b1);
        send_req(FUNC_POLL, 1'b0, 31'd3, 1'b0);
        send_req(FUNC_POLL, 1'b0, 31'd5, 1'b0);
        send_req(FUNC_POLL, 1'b0, 31'd5, 1'b1);
        send_req(FUNC_START, 1'b1, COUNT_MAX, 1'b0);
        send_req(FUNC_OPEN, 1'b1, COUNT_MAX, 1'b0);
        send_req(FUNC_POLL, 1'b0, '0, 1'b1);
        send_req(FUNC_POLL, 1'b0, COUNT_MAX - 1'b1, 1'b1);
        send_req(FUNC_CLOSE, 1'b1, COUNT_MAX, 1'b1);
        send_req(FUNC_NOP, 1'b1, COUNT_MAX, 1'b1);
        send_req(FUNC_NOP + 1'b1, 1'b0, '0, 1'b0);
        send_req(FUNC_W'(FUNC_MAX), 1'b1, 31'h2AAA_AAAA, 1'b1);
        send_req(FUNC_POLL, 1'b1, 31'h0000_0010, 1'b0);
        send_req(FUNC_START, 1'b0, 31'h5555_5555, 1'b0);
        send_req(FUNC_POLL, 1'b0, 31'h5555_5555, 1'b1);
        send_req(FUNC_POLL, 1'b1, 31'h2AAA_AAAA, 1'b1);
        send_req(FUNC_OPEN, 1'b0, '0, 1'b0);
        send_req(FUNC_POLL, 1'b1, 31'h2AAA_AAAC, 1'b1);
        bk_level = 1'b1;
        bk_count = 31'h2AAA_AAAC;
    endtask

    // Mostly plausible backend traffic, with commands, restarts and noise mixed in
    task automatic run_traffic(int items);
        int          pick;
        int unsigned step;
        repeat (items) begin
            pick = $urandom_range(99);
            if (pick < 68) begin
                step = $urandom_range(3);
                if (step == 0 && $urandom_range(3) == 0) begin
                    bk_level = !bk_level;
                end else begin
                    bk_count = COUNT_W'(bk_count + step);
                    if (step[0]) bk_level = !bk_level;
                end
                send_req(FUNC_POLL, bk_level, bk_count, $urandom_range(3) != 0);
            end else if (pick < 80) begin
                send_req(FUNC_W'($urandom_range(FUNC_OPEN, FUNC_FAIL)),
                         1'($urandom_range(1)), COUNT_W'($urandom),
                         1'($urandom_range(1)));
            end else if (pick < 86) begin
                bk_level = 1'($urandom_range(1));
                if ($urandom_range(1)) bk_count = COUNT_MAX - COUNT_W'($urandom_range(3));
                else bk_count = COUNT_W'($urandom);
                send_req(FUNC_START, bk_level, bk_count, 1'($urandom_range(1)));
            end else if (pick < 95) begin
                send_req(FUNC_POLL, 1'($urandom_range(1)), COUNT_W'($urandom),
                         1'($urandom_range(1)));
            end else begin
                send_req(FUNC_W'($urandom_range(FUNC_NOP, FUNC_MAX)),
                         1'($urandom_range(1)), COUNT_W'($urandom),
                         1'($urandom_range(1)));
            end
        end
    endtask

    initial begin
        tracker_sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Sender idles less than receiver
        tx_idle_pct = 23;
        rx_idle_pct = 50;
        write_device('1);
        run_directed();
        run_traffic(150);
        wait_idle();

        // Receiver idles less than sender
        tx_idle_pct = 50;
        rx_idle_pct = 23;
        write_device('0);
        run_traffic(150);
        wait_idle();

        // No idling, with one long sink stall up front
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_device(DEVID_W'($urandom));
        fork
            hold_sink(HOLD_CYCLES);
        join_none
        run_traffic(150);
        wait_idle();

        tracker_sb.fail_count += tracker_sb.pending();
        if (tracker_sb.fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
